// ----- src/fple_pkg.sv -----
// Shared types, constants and the CRC-32 byte step for the progress log engine.
package fple_pkg;

  localparam int SLOTS = 128;
  localparam int SLOT_W = $clog2(SLOTS + 1);

  localparam logic [31:0] LOG_MAGIC = 32'hA5A5A5A5;
  localparam logic [31:0] LOG_COMMIT = 32'h5A5A5A5A;
  localparam logic [15:0] LOG_KIND = 16'h0001;
  localparam logic [15:0] LOG_LENGTH = 16'h0004;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  // Input commands.
  localparam logic [1:0] CMD_SCAN = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_ERASE = 2'd3;

  // Result operations.
  localparam logic [2:0] OP_ACK = 3'd0;
  localparam logic [2:0] OP_ERASE = 3'd1;
  localparam logic [2:0] OP_PROG = 3'd2;
  localparam logic [2:0] OP_COMMIT = 3'd3;
  localparam logic [2:0] OP_LATEST = 3'd4;

  // Result kinds the controller asks the datapath to emit.
  localparam logic [2:0] EM_SCAN = 3'd0;
  localparam logic [2:0] EM_NREADY = 3'd1;
  localparam logic [2:0] EM_ERASE = 3'd2;
  localparam logic [2:0] EM_READ = 3'd3;
  localparam logic [2:0] EM_WRAP = 3'd4;
  localparam logic [2:0] EM_BODY = 3'd5;
  localparam logic [2:0] EM_COMMIT = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] rec_magic;
    logic [15:0] rec_kind;
    logic [15:0] rec_length;
    logic [31:0] rec_sequence;
    logic [31:0] payload;
    logic [31:0] rec_check;
    logic [31:0] rec_commit;
    logic [31:0] rec_spare;
    logic        scan_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  slot;
    logic [31:0] out_sequence;
    logic [31:0] out_value;
    logic [31:0] out_check;
    logic        found;
    logic        status;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic       scan_start;
    logic       crc_start_rec;
    logic       crc_start_prog;
    logic       set_new;
    logic       emit;
    logic [2:0] emit_kind;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       crc_busy;
    logic [1:0] command;
    logic       ready;
    logic       full;
    logic       present;
  } dp_status_t;

  // One reflected CRC-32 byte update, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/fple_datapath.sv -----
// Datapath: item register, log state, byte-serial CRC unit and result register.
module fple_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  fple_pkg::in_beat_t  in_data,
  input  fple_pkg::dp_cmd_t   cmd,
  output fple_pkg::dp_status_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output fple_pkg::out_beat_t out_data
);
  import fple_pkg::*;

  localparam logic [SLOT_W-1:0] SLOTS_V = SLOT_W'(SLOTS);

  in_beat_t item;

  logic              latest_present;
  logic [31:0]       latest_sequence;
  logic [31:0]       latest_value_reg;
  logic [6:0]        latest_slot;
  logic [SLOT_W-1:0] next_write_slot;
  logic [SLOT_W-1:0] first_blank_slot;
  logic [SLOT_W-1:0] scan_position;
  logic              ready;

  logic [31:0] prog_seq;
  logic [31:0] prog_val;

  logic        crc_busy;
  logic        crc_src_rec;
  logic [3:0]  crc_idx;
  logic [31:0] crc;
  logic [31:0] crc_out;
  logic [15:0][7:0] crc_bytes;

  logic              out_free;
  logic              in_region;
  logic              blank;
  logic              rec_ok;
  logic              take;
  logic              found_scan;
  logic [SLOT_W-1:0] blank_next;
  out_beat_t         res;

  // Hold the accepted item for the whole run.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
  end

  // CRC source bytes in little-endian order: magic, kind, length, sequence, value.
  always_comb begin
    if (crc_src_rec) begin
      crc_bytes = {item.payload, item.rec_sequence, item.rec_length, item.rec_kind,
                   item.rec_magic};
    end else begin
      crc_bytes = {prog_val, prog_seq, LOG_LENGTH, LOG_KIND, LOG_MAGIC};
    end
  end

  assign crc_out = crc ^ ALL_ONES;

  // One byte per cycle through the CRC register.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_busy <= 1'b0;
      crc_idx <= '0;
    end else if (cmd.crc_start_rec || cmd.crc_start_prog) begin
      crc_busy <= 1'b1;
      crc_idx <= '0;
      crc_src_rec <= cmd.crc_start_rec;
      crc <= ALL_ONES;
    end else if (crc_busy) begin
      crc <= crc_byte(crc, crc_bytes[crc_idx]);
      crc_idx <= crc_idx + 4'd1;
      if (crc_idx == 4'd15) begin
        crc_busy <= 1'b0;
      end
    end
  end

  // Classify the scanned record.
  always_comb begin
    in_region = scan_position < SLOTS_V;
    blank = (item.rec_magic == ALL_ONES) && (item.rec_kind == 16'hFFFF) &&
            (item.rec_length == 16'hFFFF) && (item.rec_sequence == ALL_ONES) &&
            (item.payload == ALL_ONES) && (item.rec_check == ALL_ONES) &&
            (item.rec_commit == ALL_ONES) && (item.rec_spare == ALL_ONES);
    rec_ok = (item.rec_magic == LOG_MAGIC) && (item.rec_commit == LOG_COMMIT) &&
             (item.rec_kind == LOG_KIND) && (item.rec_length == LOG_LENGTH) &&
             (item.rec_check == crc_out);
    take = in_region && !blank && rec_ok &&
           (!latest_present || (item.rec_sequence > latest_sequence));
    found_scan = latest_present || take;
    blank_next = first_blank_slot;
    if (in_region && blank && (first_blank_slot == SLOTS_V)) begin
      blank_next = scan_position;
    end
  end

  // Log state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      latest_present <= 1'b0;
      latest_sequence <= '0;
      latest_value_reg <= '0;
      latest_slot <= '0;
      next_write_slot <= '0;
      first_blank_slot <= SLOTS_V;
      scan_position <= '0;
      ready <= 1'b0;
    end else begin
      if (cmd.scan_start && (scan_position == '0)) begin
        latest_present <= 1'b0;
        latest_sequence <= '0;
        latest_value_reg <= '0;
        latest_slot <= '0;
        first_blank_slot <= SLOTS_V;
        ready <= 1'b0;
      end
      if (cmd.set_new) begin
        prog_seq <= latest_present ? (latest_sequence + 32'd1) : 32'd0;
        prog_val <= item.payload;
      end
      if (cmd.emit) begin
        unique case (cmd.emit_kind)
          EM_SCAN: begin
            first_blank_slot <= blank_next;
            if (take) begin
              latest_present <= 1'b1;
              latest_sequence <= item.rec_sequence;
              latest_value_reg <= item.payload;
              latest_slot <= scan_position[6:0];
            end
            if (item.scan_end) begin
              next_write_slot <= blank_next;
              ready <= 1'b1;
              scan_position <= '0;
            end else if (in_region) begin
              scan_position <= scan_position + SLOT_W'(1);
            end
          end
          EM_ERASE: begin
            latest_present <= 1'b0;
            latest_sequence <= '0;
            latest_value_reg <= '0;
            latest_slot <= '0;
            next_write_slot <= '0;
            first_blank_slot <= SLOTS_V;
            scan_position <= '0;
            ready <= 1'b1;
          end
          EM_WRAP: begin
            prog_seq <= latest_sequence + 32'd1;
            prog_val <= latest_value_reg;
            latest_present <= 1'b0;
            latest_sequence <= '0;
            latest_value_reg <= '0;
            latest_slot <= '0;
            next_write_slot <= '0;
          end
          EM_COMMIT: begin
            latest_present <= 1'b1;
            latest_sequence <= prog_seq;
            latest_value_reg <= prog_val;
            latest_slot <= next_write_slot[6:0];
            if (next_write_slot < SLOTS_V) begin
              next_write_slot <= next_write_slot + SLOT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Build the result for the requested kind.
  always_comb begin
    res = '0;
    res.last_of_run = cmd.last;
    unique case (cmd.emit_kind)
      EM_SCAN: begin
        res.op = OP_ACK;
        res.slot = scan_position[6:0];
        res.found = found_scan;
      end
      EM_NREADY: begin
        res.op = OP_ACK;
        res.status = 1'b1;
      end
      EM_ERASE, EM_WRAP: begin
        res.op = OP_ERASE;
      end
      EM_READ: begin
        res.op = OP_LATEST;
        res.slot = latest_slot;
        res.out_sequence = latest_present ? latest_sequence : 32'd0;
        res.out_value = latest_present ? latest_value_reg : 32'd0;
        res.found = latest_present;
      end
      EM_BODY, EM_COMMIT: begin
        res.op = (cmd.emit_kind == EM_BODY) ? OP_PROG : OP_COMMIT;
        res.slot = next_write_slot[6:0];
        res.out_sequence = prog_seq;
        res.out_value = prog_val;
        res.out_check = crc_out;
        res.found = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      out_data <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_free = out_free;
  assign stat.crc_busy = crc_busy;
  assign stat.command = item.command;
  assign stat.ready = ready;
  assign stat.full = next_write_slot >= SLOTS_V;
  assign stat.present = latest_present;

endmodule

// ----- src/fple_controller.sv -----
// Controller: sequences each command through CRC runs and result beats.
module fple_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  output logic                 in_ready,
  input  fple_pkg::dp_status_t stat,
  output fple_pkg::dp_cmd_t    cmd
);
  import fple_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ONE = 4'd2;
  localparam logic [3:0] S_CRC_SCAN = 4'd3;
  localparam logic [3:0] S_SCAN_EMIT = 4'd4;
  localparam logic [3:0] S_WRAP = 4'd5;
  localparam logic [3:0] S_CRC_KEEP = 4'd6;
  localparam logic [3:0] S_BODY_K = 4'd7;
  localparam logic [3:0] S_COMMIT_K = 4'd8;
  localparam logic [3:0] S_NEW = 4'd9;
  localparam logic [3:0] S_CRC_NEW = 4'd10;
  localparam logic [3:0] S_BODY_N = 4'd11;
  localparam logic [3:0] S_COMMIT_N = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] one_kind;
  logic [2:0] one_kind_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      one_kind <= EM_ERASE;
    end else begin
      state <= state_next;
      one_kind <= one_kind_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    one_kind_next = one_kind;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.command == CMD_SCAN) begin
          cmd.scan_start = 1'b1;
          cmd.crc_start_rec = 1'b1;
          state_next = S_CRC_SCAN;
        end else if (stat.command == CMD_ERASE) begin
          one_kind_next = EM_ERASE;
          state_next = S_ONE;
        end else if (!stat.ready) begin
          one_kind_next = EM_NREADY;
          state_next = S_ONE;
        end else if (stat.command == CMD_READ) begin
          one_kind_next = EM_READ;
          state_next = S_ONE;
        end else if (stat.full) begin
          state_next = S_WRAP;
        end else begin
          state_next = S_NEW;
        end
      end
      S_ONE: begin
        cmd.emit_kind = one_kind;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CRC_SCAN: begin
        if (!stat.crc_busy) begin
          state_next = S_SCAN_EMIT;
        end
      end
      S_SCAN_EMIT: begin
        cmd.emit_kind = EM_SCAN;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WRAP: begin
        cmd.emit_kind = EM_WRAP;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.present) begin
            cmd.crc_start_prog = 1'b1;
            state_next = S_CRC_KEEP;
          end else begin
            state_next = S_NEW;
          end
        end
      end
      S_CRC_KEEP: begin
        if (!stat.crc_busy) begin
          state_next = S_BODY_K;
        end
      end
      S_BODY_K: begin
        cmd.emit_kind = EM_BODY;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_COMMIT_K;
        end
      end
      S_COMMIT_K: begin
        cmd.emit_kind = EM_COMMIT;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_NEW;
        end
      end
      S_NEW: begin
        cmd.set_new = 1'b1;
        cmd.crc_start_prog = 1'b1;
        state_next = S_CRC_NEW;
      end
      S_CRC_NEW: begin
        if (!stat.crc_busy) begin
          state_next = S_BODY_N;
        end
      end
      S_BODY_N: begin
        cmd.emit_kind = EM_BODY;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_COMMIT_N;
        end
      end
      S_COMMIT_N: begin
        cmd.emit_kind = EM_COMMIT;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/flash_progress_log_engine.sv -----
// Top level of the flash progress log engine.
// The engine takes one command beat at a time and answers with one to five result beats.
// Scan, write, read and erase commands are sequenced by a controller; every record CRC is
// computed by a byte-serial CRC-32 unit, one of the 16 body bytes per cycle. A scan beat
// runs decode, CRC and its result; read, erase and not-ready commands answer with one beat;
// a write runs CRC and two program beats; a write into a full region sends an erase beat,
// CRC and two program beats for the carried-over record, then CRC and two beats for the
// new one, and any beat waits while the output stalls. The next command is accepted once
// the final result beat of the previous one sits in the output register.
module flash_progress_log_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fple_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fple_pkg::out_beat_t out_data
);
  import fple_pkg::*;

  logic       in_fire;
  dp_cmd_t    cmd;
  dp_status_t stat;

  assign in_fire = in_valid && in_ready;

  fple_controller u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .in_ready(in_ready),
    .stat(stat),
    .cmd(cmd)
  );

  fple_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .in_data(in_data),
    .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

// ----- src/fple_checker.sv -----
// Port-level checker for the progress log engine, bound to the top level.
module fple_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input fple_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input fple_pkg::out_beat_t out_data
);
  import fple_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A waiting command beat holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("command beat changed while waiting");

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // A program body beat always has its commit beat after it.
  a_body_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.op == OP_PROG |-> out_data.found && !out_data.last_of_run)
    else $error("program body ended a run");

  // A not-ready answer is a lone acknowledge.
  a_nready_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.op == OP_ACK && out_data.last_of_run)
    else $error("not-ready status on a wrong beat");

endmodule

bind flash_progress_log_engine fple_checker u_fple_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the flash progress log engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fple_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  out_beat_t out_data;

  flash_progress_log_engine u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Log state as the engine should hold it.
  logic        lg_present;
  logic [31:0] lg_seq;
  logic [31:0] lg_val;
  logic [6:0]  lg_slot;
  int          lg_next;
  int          lg_blank;
  int          lg_pos;
  logic        lg_ready;

  out_beat_t pending_beats[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int idle_watch;

  function automatic logic [31:0] record_crc(input logic [31:0] seq, input logic [31:0] val);
    logic [127:0] bytes;
    logic [31:0]  c;
    bytes = {val, seq, LOG_LENGTH, LOG_KIND, LOG_MAGIC};
    c = ALL_ONES;
    for (int i = 0; i < 16; i++) begin
      c = c ^ {24'd0, bytes[8*i +: 8]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c ^ ALL_ONES;
  endfunction

  function automatic out_beat_t mk_beat(input logic [2:0] op, input logic [6:0] slot,
                                        input logic [31:0] seq, input logic [31:0] val,
                                        input logic [31:0] chk, input logic fnd,
                                        input logic st);
    out_beat_t b;
    b = '{op, slot, seq, val, chk, fnd, st, 1'b0};
    return b;
  endfunction

  function automatic void clear_latest();
    lg_present = 1'b0;
    lg_seq = '0;
    lg_val = '0;
    lg_slot = '0;
  endfunction

  function automatic void queue_program(input logic [31:0] val, input logic [31:0] seq);
    logic [31:0] chk;
    chk = record_crc(seq, val);
    pending_beats.push_back(mk_beat(OP_PROG, lg_next[6:0], seq, val, chk, 1'b1, 1'b0));
    pending_beats.push_back(mk_beat(OP_COMMIT, lg_next[6:0], seq, val, chk, 1'b1, 1'b0));
    lg_present = 1'b1;
    lg_seq = seq;
    lg_val = val;
    lg_slot = lg_next[6:0];
    if (lg_next < SLOTS) lg_next++;
  endfunction

  // Predict the result beats of one accepted command.
  function automatic void predict_log(input in_beat_t b);
    int first;
    int pos;
    logic [31:0] nseq;
    logic keep;
    logic [31:0] kseq;
    logic [31:0] kval;
    out_beat_t last;
    first = pending_beats.size();
    if (b.command == CMD_SCAN) begin
      if (lg_pos == 0) begin
        clear_latest();
        lg_blank = SLOTS;
        lg_ready = 1'b0;
      end
      pos = lg_pos;
      if (pos < SLOTS) begin
        if (b.rec_magic == ALL_ONES && b.rec_kind == 16'hFFFF && b.rec_length == 16'hFFFF &&
            b.rec_sequence == ALL_ONES && b.payload == ALL_ONES && b.rec_check == ALL_ONES &&
            b.rec_commit == ALL_ONES && b.rec_spare == ALL_ONES) begin
          if (lg_blank == SLOTS) lg_blank = pos;
        end else if (b.rec_magic == LOG_MAGIC && b.rec_commit == LOG_COMMIT &&
                     b.rec_kind == LOG_KIND && b.rec_length == LOG_LENGTH &&
                     b.rec_check == record_crc(b.rec_sequence, b.payload)) begin
          if (!lg_present || b.rec_sequence > lg_seq) begin
            lg_present = 1'b1;
            lg_seq = b.rec_sequence;
            lg_val = b.payload;
            lg_slot = pos[6:0];
          end
        end
        lg_pos = pos + 1;
      end
      pending_beats.push_back(mk_beat(OP_ACK, pos[6:0], '0, '0, '0, lg_present, 1'b0));
      if (b.scan_end) begin
        lg_next = lg_blank;
        lg_ready = 1'b1;
        lg_pos = 0;
      end
    end else if (b.command == CMD_ERASE) begin
      pending_beats.push_back(mk_beat(OP_ERASE, '0, '0, '0, '0, 1'b0, 1'b0));
      clear_latest();
      lg_next = 0;
      lg_blank = SLOTS;
      lg_pos = 0;
      lg_ready = 1'b1;
    end else if (!lg_ready) begin
      pending_beats.push_back(mk_beat(OP_ACK, '0, '0, '0, '0, 1'b0, 1'b1));
    end else if (b.command == CMD_READ) begin
      if (lg_present)
        pending_beats.push_back(mk_beat(OP_LATEST, lg_slot, lg_seq, lg_val, '0, 1'b1, 1'b0));
      else
        pending_beats.push_back(mk_beat(OP_LATEST, lg_slot, '0, '0, '0, 1'b0, 1'b0));
    end else begin
      if (lg_next >= SLOTS) begin
        keep = lg_present;
        kseq = lg_seq;
        kval = lg_val;
        pending_beats.push_back(mk_beat(OP_ERASE, '0, '0, '0, '0, 1'b0, 1'b0));
        clear_latest();
        lg_next = 0;
        if (keep) queue_program(kval, kseq + 32'd1);
      end
      nseq = lg_present ? lg_seq + 32'd1 : 32'd0;
      queue_program(b.payload, nseq);
    end
    last = pending_beats[pending_beats.size() - 1];
    last.last_of_run = 1'b1;
    pending_beats[pending_beats.size() - 1] = last;
  endfunction

  // Send one command beat and record what it should produce.
  task automatic send_beat(input in_beat_t b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_log(b);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_beat_t noise_beat(input logic [1:0] cmd);
    in_beat_t b;
    logic [255:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    b = r[$bits(in_beat_t)-1:0];
    b.command = cmd;
    b.scan_end = 1'b0;
    return b;
  endfunction

  function automatic in_beat_t blank_beat();
    in_beat_t b;
    b = '1;
    b.command = CMD_SCAN;
    b.scan_end = 1'b0;
    return b;
  endfunction

  function automatic in_beat_t valid_beat(input logic [31:0] seq, input logic [31:0] val);
    in_beat_t b;
    b = '{CMD_SCAN, LOG_MAGIC, LOG_KIND, LOG_LENGTH, seq, val, record_crc(seq, val),
          LOG_COMMIT, $urandom, 1'b0};
    return b;
  endfunction

  // One scan record with random class: valid, blank, nearly valid or noise.
  function automatic in_beat_t scan_record(input logic [31:0] seq_base);
    in_beat_t b;
    int k;
    k = $urandom_range(9);
    if (k < 5) begin
      b = valid_beat(seq_base + $urandom_range(40), $urandom);
    end else if (k < 7) begin
      b = blank_beat();
    end else if (k < 9) begin
      b = ($urandom_range(1)) ? valid_beat($urandom, $urandom) : blank_beat();
      case ($urandom_range(7))
        0: b.rec_magic[$urandom_range(31)] ^= 1'b1;
        1: b.rec_kind[$urandom_range(15)] ^= 1'b1;
        2: b.rec_length[$urandom_range(15)] ^= 1'b1;
        3: b.rec_sequence[$urandom_range(31)] ^= 1'b1;
        4: b.payload[$urandom_range(31)] ^= 1'b1;
        5: b.rec_check[$urandom_range(31)] ^= 1'b1;
        6: b.rec_commit[$urandom_range(31)] ^= 1'b1;
        default: b.rec_spare[$urandom_range(31)] ^= 1'b1;
      endcase
    end else begin
      b = noise_beat(CMD_SCAN);
    end
    return b;
  endfunction

  // Scan a pass of n records; the last one carries scan_end.
  task automatic scan_pass(input int n, input logic [31:0] seq_base);
    in_beat_t b;
    for (int i = 0; i < n; i++) begin
      b = scan_record(seq_base);
      b.scan_end = (i == n - 1);
      send_beat(b);
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // Directed: not-ready, extremes, blank and valid records, full-region wrap.
  task automatic test_directed();
    in_beat_t b;
    send_beat(noise_beat(CMD_WRITE));
    send_beat(noise_beat(CMD_READ));
    b = valid_beat(32'hFFFF_FFFE, 32'h0);
    send_beat(b);
    b = valid_beat(32'h0, ALL_ONES);
    send_beat(b);
    send_beat(blank_beat());
    b = '0;
    send_beat(b);
    b = blank_beat();
    b.rec_spare = 32'hFFFF_FFFE;
    b.scan_end = 1'b1;
    send_beat(b);
    send_beat(noise_beat(CMD_READ));
    send_beat(noise_beat(CMD_WRITE));
    send_beat(noise_beat(CMD_WRITE));
    send_beat(noise_beat(CMD_READ));
    send_beat(noise_beat(CMD_ERASE));
    send_beat(noise_beat(CMD_READ));
    send_beat(noise_beat(CMD_WRITE));
    // A pass with no blank slot leaves the region full, so the next write wraps.
    b = valid_beat(32'd7, 32'h1234_5678);
    send_beat(b);
    b = valid_beat(32'd3, 32'h0);
    b.scan_end = 1'b1;
    send_beat(b);
    send_beat(noise_beat(CMD_WRITE));
    send_beat(noise_beat(CMD_READ));
    // An empty full region wraps without a carried record.
    b = noise_beat(CMD_SCAN);
    b.scan_end = 1'b1;
    send_beat(b);
    send_beat(noise_beat(CMD_WRITE));
  endtask

  // A pass longer than the region: positions saturate and later records are ignored.
  task automatic test_overlong_scan();
    in_beat_t b;
    for (int i = 0; i < SLOTS + 3; i++) begin
      b = (i == SLOTS + 1) ? blank_beat() : valid_beat(i, $urandom);
      b.scan_end = (i == SLOTS + 2);
      send_beat(b);
    end
    send_beat(noise_beat(CMD_READ));
    send_beat(noise_beat(CMD_WRITE));
    send_beat(noise_beat(CMD_WRITE));
  endtask

  // Many writes until the region fills and wraps.
  task automatic test_fill_and_wrap();
    send_beat(noise_beat(CMD_ERASE));
    for (int i = 0; i < SLOTS + 2; i++) send_beat(noise_beat(CMD_WRITE));
    send_beat(noise_beat(CMD_READ));
  endtask

  // Random mix of scan passes and commands.
  task automatic test_random(input int items);
    int sent;
    int k;
    int n;
    sent = 0;
    while (sent < items) begin
      k = $urandom_range(99);
      if (k < 35) begin
        n = $urandom_range(1, 6);
        scan_pass(n, $urandom_range(1) ? 32'hFFFF_FFC0 : $urandom_range(100));
        sent += n;
      end else if (k < 40) begin
        send_beat(scan_record(0));
        sent++;
      end else begin
        k = $urandom_range(99);
        send_beat(noise_beat(k < 65 ? CMD_WRITE : (k < 90 ? CMD_READ : CMD_ERASE)));
        sent++;
      end
    end
  endtask

  // Receiver stalls for a long stretch while commands keep coming.
  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 10; i++) send_beat(noise_beat(CMD_WRITE));
    wait_drained();
    for (int i = 0; i < 10; i++) send_beat(noise_beat(CMD_READ));
  endtask

  // Receiver side: random stalls, plus a counted hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", out_data);
      end else begin
        want = pending_beats.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_watch <= 0;
    end else begin
      idle_watch <= idle_watch + 1;
      if (idle_watch >= WATCH_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    hold_cycles = 0;
    idle_watch = 0;
    send_idle_pct = 22;
    recv_idle_pct = 73;
    lg_present = 1'b0;
    lg_seq = '0;
    lg_val = '0;
    lg_slot = '0;
    lg_next = 0;
    lg_blank = SLOTS;
    lg_pos = 0;
    lg_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(30);
    send_idle_pct = 73;
    recv_idle_pct = 22;
    test_overlong_scan();
    test_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_and_wrap();
    test_backpressure();
    test_random(40);
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
